FILE: hdl/nnue_accumulator_engine_top_assert.svh
// assertion macros shared by the accumulator engine
`ifndef NNUE_ACCUMULATOR_ENGINE_TOP_ASSERT_SVH
`define NNUE_ACCUMULATOR_ENGINE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define NNUE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define NNUE_NEVER(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error(msg);
`else
`define NNUE_ASSERT(lbl, clk, rstn, prop, msg)
`define NNUE_NEVER(lbl, clk, rstn, prop, msg)
`endif
`endif

FILE: hdl/nnue_acc_pkg.sv
`default_nettype none
package nnue_acc_pkg;

  localparam int HALF_DIMENSIONS_DEF = 2048;
  localparam int LANES_DEF           = 8;
  localparam int MAX_LANES           = 8;
  localparam int LANE_W              = 16;
  localparam int CLIP_W              = 8;
  localparam int CHUNK_W             = 8;
  localparam int COUNT_W             = 13;
  localparam int BASE_W              = 12;
  localparam int POP_W               = 4;
  localparam int QUEUE_DEPTH         = 2;
  localparam int IN_USER_W           = 2;

  typedef enum logic [IN_USER_W-1:0] {
    CMD_LOAD = 2'd0,
    CMD_ADD  = 2'd1,
    CMD_SUB  = 2'd2,
    CMD_EMIT = 2'd3
  } cmd_t;

  typedef logic signed [LANE_W-1:0] lane_t;

  // input tdata layout, lowest bits last in the list
  typedef struct packed {
    logic [6:0]                pad;
    lane_t [MAX_LANES-1:0]     lanes;
    logic [CHUNK_W-1:0]        chunk;
    logic                      persp;
  } in_data_t;

  localparam int IN_DATA_W = $bits(in_data_t);

  // classified item as it travels through the queue
  typedef struct packed {
    cmd_t                      cmd;
    logic                      persp;
    logic [CHUNK_W-1:0]        chunk;
    logic                      restart;
    logic [BASE_W-1:0]         base;
    lane_t [MAX_LANES-1:0]     lanes;
  } item_t;

  typedef struct packed {
    logic [6:0]                          pad;
    logic [BASE_W-1:0]                   base;
    logic [COUNT_W-1:0]                  offset;
    logic [MAX_LANES-1:0]                mask;
    logic [MAX_LANES-1:0][CLIP_W-1:0]    clips;
  } result_t;

  localparam int OUT_DATA_W = $bits(result_t);

endpackage
`default_nettype wire

FILE: hdl/nnue_acc_ram.sv
`default_nettype none
module nnue_acc_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/nnue_acc_front.sv
`default_nettype none
module nnue_acc_front #(
  parameter int HALF_DIMENSIONS = nnue_acc_pkg::HALF_DIMENSIONS_DEF,
  parameter int LANES           = nnue_acc_pkg::LANES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [nnue_acc_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic [nnue_acc_pkg::IN_USER_W-1:0]  in_tuser,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic                                cfg_data,
  input  wire logic                                q_full,
  output logic                                     q_push,
  output nnue_acc_pkg::item_t                      q_item
);
  import nnue_acc_pkg::*;

  localparam int ROWS_RAW      = HALF_DIMENSIONS / LANES;
  localparam int ROWS_PER_HALF = (ROWS_RAW > (1 << CHUNK_W)) ? (1 << CHUNK_W) : ROWS_RAW;
  localparam logic [CHUNK_W:0] ROW_LIMIT = (CHUNK_W+1)'(ROWS_PER_HALF);
  localparam logic [BASE_W-1:0] HALF_OFS = BASE_W'(HALF_DIMENSIONS);
  localparam logic [BASE_W-1:0] LANE_MUL = BASE_W'(LANES);

  logic     stm_r;
  logic     stm_nxt;
  in_data_t d;
  logic     in_range;
  logic     half;

  assign cfg_ready = 1'b1;
  assign stm_nxt   = cfg_valid ? cfg_data : stm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stm_r <= 1'b0;
    end else begin
      stm_r <= stm_nxt;
    end
  end

  assign d        = in_tdata;
  // chunks that run past the half are dropped here
  assign in_range = {1'b0, d.chunk} < ROW_LIMIT;
  assign half     = d.persp ^ stm_r;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full && in_range;

  always_comb begin
    q_item.cmd     = cmd_t'(in_tuser);
    q_item.persp   = d.persp;
    q_item.chunk   = d.chunk;
    q_item.restart = !half && (d.chunk == '0);
    q_item.base    = (half ? HALF_OFS : '0) + BASE_W'(d.chunk) * LANE_MUL;
    q_item.lanes   = d.lanes;
  end

endmodule
`default_nettype wire

FILE: hdl/nnue_acc_fifo.sv
`default_nettype none
`include "nnue_accumulator_engine_top_assert.svh"
module nnue_acc_fifo #(
  parameter int DEPTH = nnue_acc_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire nnue_acc_pkg::item_t push_item,
  output logic                    full,
  input  wire logic               pop,
  output logic                    empty,
  output nnue_acc_pkg::item_t     head
);
  import nnue_acc_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  item_t         mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full  = cnt_r == CW'(DEPTH);
  assign empty = cnt_r == '0;
  assign head  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == LAST) ? '0 : wp_r + PW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == LAST) ? '0 : rp_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

  `NNUE_NEVER(a_push_full, clk, rst_n, push && full, "push into full queue")
  `NNUE_NEVER(a_pop_empty, clk, rst_n, pop && empty, "pop from empty queue")
  `NNUE_ASSERT(a_cnt_inc, clk, rst_n, push && !pop |=> cnt_r == $past(cnt_r) + CW'(1), "no grow")

endmodule
`default_nettype wire

FILE: hdl/nnue_acc_back.sv
`default_nettype none
`include "nnue_accumulator_engine_top_assert.svh"
module nnue_acc_back #(
  parameter int HALF_DIMENSIONS = nnue_acc_pkg::HALF_DIMENSIONS_DEF,
  parameter int LANES           = nnue_acc_pkg::LANES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                q_empty,
  input  wire nnue_acc_pkg::item_t                 q_head,
  output logic                                     q_pop,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [nnue_acc_pkg::OUT_DATA_W-1:0]      out_tdata
);
  import nnue_acc_pkg::*;

  localparam int ROWS_RAW      = HALF_DIMENSIONS / LANES;
  localparam int ROWS_PER_HALF = (ROWS_RAW > (1 << CHUNK_W)) ? (1 << CHUNK_W) : ROWS_RAW;
  localparam int ROW_AW        = $clog2(ROWS_PER_HALF);
  localparam int RAM_DEPTH     = 2 * (1 << ROW_AW);
  localparam int ROW_W         = LANES * LANE_W;
  localparam lane_t SAT_HI     = 16'sd127;
  localparam lane_t SAT_LO     = -16'sd128;
  localparam logic [CLIP_W-1:0] CLIP_HI = 8'h7f;
  localparam logic [CLIP_W-1:0] CLIP_LO = 8'h80;

  item_t                 s1_r;
  logic                  s1_valid_r, s1_valid_nxt;
  logic                  out_valid_r, out_valid_nxt;
  result_t               out_data_r;
  result_t               res;
  logic [COUNT_W-1:0]    count_r, count_nxt, cnt_base;

  logic                  ram_we;
  logic [ROW_AW:0]       ram_waddr, ram_raddr;
  logic [ROW_W-1:0]      ram_wdata, ram_rdata;

  logic                  is_emit;
  logic                  emit_go;
  logic [MAX_LANES-1:0][CLIP_W-1:0] clip_w;
  logic [MAX_LANES-1:0]  pos_w;
  logic [POP_W-1:0]      pos_cnt;

  // one item at a time: read the row, then write it back or emit it
  assign q_pop     = !s1_valid_r && !q_empty;
  assign ram_raddr = {q_head.persp, q_head.chunk[ROW_AW-1:0]};
  assign ram_waddr = {s1_r.persp, s1_r.chunk[ROW_AW-1:0]};

  assign is_emit = s1_r.cmd == CMD_EMIT;
  assign ram_we  = s1_valid_r && !is_emit;
  assign emit_go = s1_valid_r && is_emit && (!out_valid_r || out_tready);

  nnue_acc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (q_pop),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  for (genvar k = 0; k < MAX_LANES; k++) begin : g_lane
    if (k < LANES) begin : g_used
      lane_t cur;
      lane_t arg;
      lane_t upd;

      assign cur = ram_rdata[k*LANE_W +: LANE_W];
      assign arg = s1_r.lanes[k];

      always_comb begin
        unique case (s1_r.cmd)
          CMD_LOAD: upd = arg;
          CMD_ADD:  upd = cur + arg;
          CMD_SUB:  upd = cur - arg;
          CMD_EMIT: upd = cur;
          default:  upd = cur;
        endcase
      end
      assign ram_wdata[k*LANE_W +: LANE_W] = upd;

      always_comb begin
        if (cur > SAT_HI) begin
          clip_w[k] = CLIP_HI;
        end else if (cur < SAT_LO) begin
          clip_w[k] = CLIP_LO;
        end else begin
          clip_w[k] = cur[CLIP_W-1:0];
        end
      end
      assign pos_w[k] = !cur[LANE_W-1] && (cur != '0);
    end else begin : g_unused
      assign clip_w[k] = '0;
      assign pos_w[k]  = 1'b0;
    end
  end

  assign pos_cnt  = POP_W'($countones(pos_w));
  // first chunk of the side-to-move half restarts the running count
  assign cnt_base = s1_r.restart ? '0 : count_r;

  always_comb begin
    res.pad    = '0;
    res.base   = s1_r.base;
    res.offset = cnt_base;
    res.mask   = pos_w;
    res.clips  = clip_w;
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (q_pop) begin
      s1_valid_nxt = 1'b1;
    end else if (ram_we || emit_go) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (emit_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    count_nxt = emit_go ? cnt_base + COUNT_W'(pos_cnt) : count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_r <= q_head;
    end
    if (emit_go) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `NNUE_ASSERT(a_pop_fill, clk, rst_n, q_pop |=> s1_valid_r, "popped item not held")
  `NNUE_NEVER(a_wr_emit, clk, rst_n, ram_we && (s1_r.cmd == CMD_EMIT), "emit wrote the store")
  `NNUE_ASSERT(a_wr_done, clk, rst_n, ram_we |=> !s1_valid_r, "update did not retire")
  `NNUE_ASSERT(a_out_load, clk, rst_n, emit_go |=> out_valid_r, "emit result lost")

endmodule
`default_nettype wire

FILE: hdl/nnue_accumulator_engine_top.sv
// path: an accepted load, add, subtract or emit passes through the queue into the held
//   item stage, which reads its row through the store's registered read port; an update
//   is written back, an emit result is registered onto out_tvalid; items go one at a time,
//   a new one waiting for the last to retire; out-of-range chunks are dropped at the input
// reset (rst_n low, synchronous): queue, stages, count and side_to_move cleared;
//   the accumulator store is not cleared and must be loaded before use
`default_nettype none
module nnue_accumulator_engine_top #(
  parameter int HALF_DIMENSIONS = nnue_acc_pkg::HALF_DIMENSIONS_DEF,
  parameter int LANES           = nnue_acc_pkg::LANES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // perspective, chunk_index, lane_0 .. lane_7, zero pad
  input  wire logic [nnue_acc_pkg::IN_DATA_W-1:0]  in_tdata,
  // command
  input  wire logic [nnue_acc_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // clip_0 .. clip_7, positive_mask, nonzero_offset, output_base, zero pad
  output logic [nnue_acc_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  // side_to_move
  input  wire logic                                cfg_data
);
  import nnue_acc_pkg::*;

  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;
  item_t q_item;
  item_t q_head;

  nnue_acc_front #(
    .HALF_DIMENSIONS (HALF_DIMENSIONS),
    .LANES           (LANES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_item)
  );

  nnue_acc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  nnue_acc_back #(
    .HALF_DIMENSIONS (HALF_DIMENSIONS),
    .LANES           (LANES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire
